>>> rtl/gpm_pkg.sv
// Shared types and constants for the glob pattern matcher.
`timescale 1ns / 1ps

package gpm_pkg;

    localparam int PATTERN_DEPTH_DEF = 64;
    localparam int TEXT_DEPTH_DEF    = 256;

    localparam logic [1:0] OP_PAT = 2'd0;
    localparam logic [1:0] OP_TXT = 2'd1;
    localparam logic [1:0] OP_RUN = 2'd2;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_RD,
        ST_T_USE,
        ST_P_USE,
        ST_ESC,
        ST_C_NEG,
        ST_C_HEAD,
        ST_C_ESC,
        ST_C_DASH,
        ST_C_HI,
        ST_C_HESC,
        ST_S_RD,
        ST_S_USE,
        ST_FIN
    } state_t;

endpackage

>>> rtl/gpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module gpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/glob_pattern_matcher_core.sv
// Top level of the glob pattern matcher: byte stores, match sequencer and stream ports.
`timescale 1ns / 1ps

// The block takes requests on the s_ stream: operation 0 appends a pattern byte,
// operation 1 appends a text byte and operation 2 runs the match. Zero bytes and
// operation 3 are dropped. Appends are taken every cycle while no run is in progress,
// also while a result still waits on the m_ side.
// A run request yields one result on the m_ stream: whether the whole text matches
// the shell-style pattern, and whether either store ran out of room. Both stores
// are then emptied. A run with the overflow flag set skips the walk and goes
// straight to the finish state, which registers the result.
// Otherwise the sequencer walks the two stores through their single read ports,
// one byte read at a time through the registered read port, stepping through the
// pattern bytes visited and backtracking after a star.
// While a run is in progress s_tready is low. A further run request waits until
// the previous result has been taken; appends do not.
// After reset both stores are empty and the overflow flag is clear; the stored
// bytes are not cleared, as only bytes below the fill counts are ever read.
// A stalled receiver simply holds the result in the output register.

module glob_pattern_matcher_core #(
    parameter int PATTERN_DEPTH = gpm_pkg::PATTERN_DEPTH_DEF,
    parameter int TEXT_DEPTH    = gpm_pkg::TEXT_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operation [1:0], char_byte [9:2], zeros above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // matched [0], overflowed [1], zeros above
);

    localparam int PLW = $clog2(PATTERN_DEPTH + 1);
    localparam int TLW = $clog2(TEXT_DEPTH + 1);
    localparam int PPW = PLW + 2;
    localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

    gpm_pkg::state_t state_reg, state_next;

    logic [PLW-1:0] plen_reg, plen_next;
    logic [TLW-1:0] tlen_reg, tlen_next;
    logic           ovf_reg, ovf_next;
    logic [PPW-1:0] p_reg, p_next, sp_reg, sp_next, q_reg, q_next;
    logic [TLW-1:0] s_reg, s_next, ss_reg, ss_next;
    logic           star_reg, star_next;
    logic [7:0]     c_reg, c_next, lo_reg, lo_next;
    logic           neg_reg, neg_next, hit_reg, hit_next, first_reg, first_next;
    logic           match_reg, match_next;
    logic           pvld_reg, tvld_reg;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [1:0]     m_res_reg, m_res_next;

    logic [1:0]     op;
    logic [7:0]     byte_in;
    logic           accept;
    logic [PPW-1:0] pa;
    logic [TLW-1:0] ta;
    logic [7:0]     p_q, t_q, pb, tb;
    logic           pwe, twe;

    // Decision of one pattern step against the current text byte.
    logic           step_done, step_adv;
    logic [PPW-1:0] step_p;
    logic           cls_exit;

    assign op       = s_tdata[1:0];
    assign byte_in  = s_tdata[9:2];
    assign s_tready = (state_reg == gpm_pkg::ST_IDLE) && !(m_tvalid_reg && op == gpm_pkg::OP_RUN);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_res_reg};

    // Past the fill count a store reads as zero.
    assign pb = pvld_reg ? p_q : 8'h00;
    assign tb = tvld_reg ? t_q : 8'h00;

    assign pwe = accept && op == gpm_pkg::OP_PAT && byte_in != 8'h00
                 && plen_reg < PLW'(PATTERN_DEPTH);
    assign twe = accept && op == gpm_pkg::OP_TXT && byte_in != 8'h00
                 && tlen_reg < TLW'(TEXT_DEPTH);

    gpm_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
        .aclk  (aclk),
        .we    (pwe),
        .waddr (plen_reg[PAW-1:0]),
        .wdata (byte_in),
        .raddr (pa[PAW-1:0]),
        .rdata (p_q)
    );

    gpm_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_txt_ram (
        .aclk  (aclk),
        .we    (twe),
        .waddr (tlen_reg[TAW-1:0]),
        .wdata (byte_in),
        .raddr (ta[TAW-1:0]),
        .rdata (t_q)
    );

    // A class ends at the end of the pattern or at a closing bracket that is not first.
    assign cls_exit = (pb == 8'h00) || (pb == gpm_pkg::CH_RBRK && !first_reg);

    always_comb begin
        step_done = 1'b0;
        step_adv  = 1'b0;
        step_p    = p_reg;
        case (state_reg)
            gpm_pkg::ST_P_USE: begin
                if (pb == gpm_pkg::CH_QUEST) begin
                    step_done = 1'b1;
                    step_adv  = 1'b1;
                    step_p    = p_reg + PPW'(1);
                end else if (pb != gpm_pkg::CH_STAR && pb != gpm_pkg::CH_LBRK
                             && pb != gpm_pkg::CH_BSL) begin
                    step_done = 1'b1;
                    step_adv  = (pb != 8'h00) && (pb == c_reg);
                    step_p    = p_reg + PPW'(1);
                end
            end
            gpm_pkg::ST_ESC: begin
                // A lone trailing backslash is an ordinary literal.
                step_done = 1'b1;
                if (pb != 8'h00) begin
                    step_adv = (pb == c_reg);
                    step_p   = p_reg + PPW'(2);
                end else begin
                    step_adv = (c_reg == gpm_pkg::CH_BSL);
                    step_p   = p_reg + PPW'(1);
                end
            end
            gpm_pkg::ST_C_HEAD: begin
                if (cls_exit) begin
                    step_done = 1'b1;
                    if (pb == gpm_pkg::CH_RBRK) begin
                        step_adv = neg_reg ^ hit_reg;
                        step_p   = q_reg + PPW'(1);
                    end else begin
                        // Unterminated class: the bracket is a literal.
                        step_adv = (c_reg == gpm_pkg::CH_LBRK);
                        step_p   = p_reg + PPW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gpm_pkg::ST_IDLE: begin
                if (accept && op == gpm_pkg::OP_RUN) begin
                    state_next = ovf_reg ? gpm_pkg::ST_FIN : gpm_pkg::ST_T_RD;
                end
            end
            gpm_pkg::ST_T_RD:  state_next = gpm_pkg::ST_T_USE;
            gpm_pkg::ST_T_USE: state_next = (tb == 8'h00) ? gpm_pkg::ST_S_RD
                                                           : gpm_pkg::ST_P_USE;
            gpm_pkg::ST_P_USE: begin
                if (pb == gpm_pkg::CH_STAR) begin
                    state_next = gpm_pkg::ST_T_RD;
                end else if (pb == gpm_pkg::CH_LBRK) begin
                    state_next = gpm_pkg::ST_C_NEG;
                end else if (pb == gpm_pkg::CH_BSL) begin
                    state_next = gpm_pkg::ST_ESC;
                end else begin
                    state_next = (step_adv || star_reg) ? gpm_pkg::ST_T_RD : gpm_pkg::ST_FIN;
                end
            end
            gpm_pkg::ST_ESC: begin
                state_next = (step_adv || star_reg) ? gpm_pkg::ST_T_RD : gpm_pkg::ST_FIN;
            end
            gpm_pkg::ST_C_NEG: state_next = gpm_pkg::ST_C_HEAD;
            gpm_pkg::ST_C_HEAD: begin
                if (cls_exit) begin
                    state_next = (step_adv || star_reg) ? gpm_pkg::ST_T_RD : gpm_pkg::ST_FIN;
                end else if (pb == gpm_pkg::CH_BSL) begin
                    state_next = gpm_pkg::ST_C_ESC;
                end else begin
                    state_next = gpm_pkg::ST_C_DASH;
                end
            end
            gpm_pkg::ST_C_ESC:  state_next = gpm_pkg::ST_C_DASH;
            gpm_pkg::ST_C_DASH: state_next = (pb == gpm_pkg::CH_DASH) ? gpm_pkg::ST_C_HI
                                                                       : gpm_pkg::ST_C_HEAD;
            gpm_pkg::ST_C_HI: begin
                if (pb != 8'h00 && pb != gpm_pkg::CH_RBRK && pb == gpm_pkg::CH_BSL) begin
                    state_next = gpm_pkg::ST_C_HESC;
                end else begin
                    state_next = gpm_pkg::ST_C_HEAD;
                end
            end
            gpm_pkg::ST_C_HESC: state_next = gpm_pkg::ST_C_HEAD;
            gpm_pkg::ST_S_RD:   state_next = gpm_pkg::ST_S_USE;
            gpm_pkg::ST_S_USE:  state_next = (pb == gpm_pkg::CH_STAR) ? gpm_pkg::ST_S_USE
                                                                       : gpm_pkg::ST_FIN;
            gpm_pkg::ST_FIN:    state_next = gpm_pkg::ST_IDLE;
            default:            state_next = gpm_pkg::ST_IDLE;
        endcase
    end

    // Datapath registers and read addresses.
    always_comb begin
        logic [7:0] hi_v;
        hi_v          = 8'h00;
        plen_next     = plen_reg;
        tlen_next     = tlen_reg;
        ovf_next      = ovf_reg;
        p_next        = p_reg;
        sp_next       = sp_reg;
        q_next        = q_reg;
        s_next        = s_reg;
        ss_next       = ss_reg;
        star_next     = star_reg;
        c_next        = c_reg;
        lo_next       = lo_reg;
        neg_next      = neg_reg;
        hit_next      = hit_reg;
        first_next    = first_reg;
        match_next    = match_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_res_next    = m_res_reg;
        pa            = p_reg;
        ta            = s_reg;

        case (state_reg)
            gpm_pkg::ST_IDLE: begin
                if (pwe) begin
                    plen_next = plen_reg + PLW'(1);
                end
                if (twe) begin
                    tlen_next = tlen_reg + TLW'(1);
                end
                if (accept && byte_in != 8'h00 && !pwe && !twe
                    && (op == gpm_pkg::OP_PAT || op == gpm_pkg::OP_TXT)) begin
                    ovf_next = 1'b1;
                end
                if (accept && op == gpm_pkg::OP_RUN) begin
                    p_next     = '0;
                    s_next     = '0;
                    ss_next    = '0;
                    sp_next    = '0;
                    star_next  = 1'b0;
                    match_next = 1'b0;
                end
            end
            gpm_pkg::ST_T_USE: begin
                c_next = tb;
                pa     = p_reg;
            end
            gpm_pkg::ST_P_USE: begin
                if (pb == gpm_pkg::CH_STAR) begin
                    p_next    = p_reg + PPW'(1);
                    sp_next   = p_reg + PPW'(1);
                    ss_next   = s_reg;
                    star_next = 1'b1;
                end else if (pb == gpm_pkg::CH_LBRK) begin
                    q_next = p_reg + PPW'(1);
                    pa     = p_reg + PPW'(1);
                end else if (pb == gpm_pkg::CH_BSL) begin
                    pa = p_reg + PPW'(1);
                end
            end
            gpm_pkg::ST_C_NEG: begin
                hit_next   = 1'b0;
                first_next = 1'b1;
                if (pb == gpm_pkg::CH_BANG || pb == gpm_pkg::CH_CARET) begin
                    neg_next = 1'b1;
                    q_next   = q_reg + PPW'(1);
                    pa       = q_reg + PPW'(1);
                end else begin
                    neg_next = 1'b0;
                    pa       = q_reg;
                end
            end
            gpm_pkg::ST_C_HEAD: begin
                if (!cls_exit) begin
                    first_next = 1'b0;
                    if (pb == gpm_pkg::CH_BSL) begin
                        pa = q_reg + PPW'(1);
                    end else begin
                        lo_next = pb;
                        q_next  = q_reg + PPW'(1);
                        pa      = q_reg + PPW'(1);
                    end
                end
            end
            gpm_pkg::ST_C_ESC: begin
                if (pb != 8'h00) begin
                    lo_next = pb;
                    q_next  = q_reg + PPW'(2);
                    pa      = q_reg + PPW'(2);
                end else begin
                    lo_next = gpm_pkg::CH_BSL;
                    q_next  = q_reg + PPW'(1);
                    pa      = q_reg + PPW'(1);
                end
            end
            gpm_pkg::ST_C_DASH: begin
                if (pb == gpm_pkg::CH_DASH) begin
                    pa = q_reg + PPW'(1);
                end else begin
                    if (c_reg == lo_reg) begin
                        hit_next = 1'b1;
                    end
                    pa = q_reg;
                end
            end
            gpm_pkg::ST_C_HI: begin
                if (pb != 8'h00 && pb != gpm_pkg::CH_RBRK) begin
                    if (pb == gpm_pkg::CH_BSL) begin
                        pa = q_reg + PPW'(2);
                    end else begin
                        hi_v   = pb;
                        q_next = q_reg + PPW'(2);
                        pa     = q_reg + PPW'(2);
                        if (c_reg >= lo_reg && c_reg <= hi_v) begin
                            hit_next = 1'b1;
                        end
                    end
                end else begin
                    // A dash before the end or a bracket is a plain member.
                    if (c_reg == lo_reg) begin
                        hit_next = 1'b1;
                    end
                    pa = q_reg;
                end
            end
            gpm_pkg::ST_C_HESC: begin
                if (pb != 8'h00) begin
                    hi_v   = pb;
                    q_next = q_reg + PPW'(3);
                    pa     = q_reg + PPW'(3);
                end else begin
                    hi_v   = gpm_pkg::CH_BSL;
                    q_next = q_reg + PPW'(2);
                    pa     = q_reg + PPW'(2);
                end
                if (c_reg >= lo_reg && c_reg <= hi_v) begin
                    hit_next = 1'b1;
                end
            end
            gpm_pkg::ST_S_USE: begin
                if (pb == gpm_pkg::CH_STAR) begin
                    p_next = p_reg + PPW'(1);
                    pa     = p_reg + PPW'(1);
                end else begin
                    match_next = (pb == 8'h00);
                end
            end
            gpm_pkg::ST_FIN: begin
                m_tvalid_next = 1'b1;
                m_res_next    = {ovf_reg, match_reg && !ovf_reg};
                plen_next     = '0;
                tlen_next     = '0;
                ovf_next      = 1'b0;
            end
            default: begin
            end
        endcase

        // Outcome of a step: advance, backtrack to the last star, or fail.
        if (step_done) begin
            if (step_adv) begin
                p_next = step_p;
                s_next = s_reg + TLW'(1);
            end else if (star_reg) begin
                p_next  = sp_reg;
                ss_next = ss_reg + TLW'(1);
                s_next  = ss_reg + TLW'(1);
            end else begin
                match_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gpm_pkg::ST_IDLE;
            plen_reg     <= '0;
            tlen_reg     <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            plen_reg     <= plen_next;
            tlen_reg     <= tlen_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        p_reg     <= p_next;
        sp_reg    <= sp_next;
        q_reg     <= q_next;
        s_reg     <= s_next;
        ss_reg    <= ss_next;
        star_reg  <= star_next;
        c_reg     <= c_next;
        lo_reg    <= lo_next;
        neg_reg   <= neg_next;
        hit_reg   <= hit_next;
        first_reg <= first_next;
        match_reg <= match_next;
        m_res_reg <= m_res_next;
        pvld_reg  <= (pa < PPW'(plen_reg));
        tvld_reg  <= (ta < tlen_reg);
    end

`ifndef SYNTH
    a_ovf_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("match reported together with overflow");

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != gpm_pkg::ST_IDLE) |-> !s_tready)
        else $error("request taken during a run");

    a_cleared_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> (plen_reg == '0 && tlen_reg == '0 && !ovf_reg))
        else $error("stores not emptied after a run");

    a_plen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        plen_reg <= PLW'(PATTERN_DEPTH) && tlen_reg <= TLW'(TEXT_DEPTH))
        else $error("fill count beyond capacity");
`endif

endmodule

>>> tb/tb.sv
// Self-checking stream testbench for the glob pattern matcher core.
`timescale 1ns / 1ps

module tb;
    import gpm_pkg::*;

    // Operation code that the block drops.
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic       matched;
        logic       overflowed;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    glob_pattern_matcher_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    // Requests waiting to be driven, and verdicts waiting to come back.
    logic [15:0] req_queue[$];
    verdict_t    verdict_queue[$];
    int          error_count = 0;
    bit          quiet_sender = 0;
    bit          quiet_receiver = 0;
    int          hold_cycles = 0;
    bit          drain_req = 0;
    bit          s_taken = 0;

    // Predictor state.
    logic [7:0]  pat_mem[$];
    logic [7:0]  txt_mem[$];
    bit          ovf_seen = 0;

    function automatic logic [7:0] pat_at(int i);
        if (i >= pat_mem.size()) return 8'h00;
        return pat_mem[i];
    endfunction

    function automatic logic [7:0] txt_at(int i);
        if (i >= txt_mem.size()) return 8'h00;
        return txt_mem[i];
    endfunction

    // Bracket class at pos; -1 when unterminated, else hit with pos moved past ']'.
    function automatic int class_hit(ref int pos, input logic [7:0] c);
        int q;
        bit neg, hit, first;
        logic [7:0] lo, hi;
        q = pos + 1; neg = 0; hit = 0; first = 1;
        if (pat_at(q) == CH_BANG || pat_at(q) == CH_CARET) begin
            neg = 1; q++;
        end
        while (pat_at(q) != 0 && (pat_at(q) != CH_RBRK || first)) begin
            first = 0;
            if (pat_at(q) == CH_BSL && pat_at(q + 1) != 0) begin
                lo = pat_at(q + 1); q += 2;
            end else begin
                lo = pat_at(q); q += 1;
            end
            if (pat_at(q) == CH_DASH && pat_at(q + 1) != 0 && pat_at(q + 1) != CH_RBRK) begin
                q++;
                if (pat_at(q) == CH_BSL && pat_at(q + 1) != 0) begin
                    hi = pat_at(q + 1); q += 2;
                end else begin
                    hi = pat_at(q); q += 1;
                end
                if (c >= lo && c <= hi) hit = 1;
            end else if (c == lo) begin
                hit = 1;
            end
        end
        if (pat_at(q) != CH_RBRK) return -1;
        pos = q + 1;
        return (neg ? !hit : hit) ? 1 : 0;
    endfunction

    function automatic bit glob_matches();
        int p, s, sp, ss, r;
        bit star_seen, adv;
        logic [7:0] c, pc;
        p = 0; s = 0; sp = 0; ss = 0; star_seen = 0;
        while (txt_at(s) != 0) begin
            c = txt_at(s); pc = pat_at(p); adv = 0;
            if (pc == CH_STAR) begin
                p++; sp = p; ss = s; star_seen = 1;
                continue;
            end else if (pc == CH_QUEST) begin
                p++; adv = 1;
            end else if (pc == CH_LBRK) begin
                r = class_hit(p, c);
                if (r < 0) begin
                    if (pc == c) begin
                        p++; adv = 1;
                    end
                end else if (r > 0) begin
                    adv = 1;
                end
            end else if (pc == CH_BSL && pat_at(p + 1) != 0) begin
                if (pat_at(p + 1) == c) begin
                    p += 2; adv = 1;
                end
            end else if (pc != 0 && pc == c) begin
                p++; adv = 1;
            end
            if (adv) s++;
            else if (star_seen) begin
                p = sp; ss++; s = ss;
            end else return 0;
        end
        while (pat_at(p) == CH_STAR) p++;
        return pat_at(p) == 0;
    endfunction

    // Applies one accepted request to the predictor.
    task automatic predict_request(input logic [15:0] req);
        logic [1:0] op;
        logic [7:0] b;
        verdict_t v;
        op = req[1:0]; b = req[9:2];
        if (op == OP_PAT && b != 0) begin
            if (pat_mem.size() < PATTERN_DEPTH_DEF) pat_mem.push_back(b);
            else ovf_seen = 1;
        end else if (op == OP_TXT && b != 0) begin
            if (txt_mem.size() < TEXT_DEPTH_DEF) txt_mem.push_back(b);
            else ovf_seen = 1;
        end else if (op == OP_RUN) begin
            v.overflowed = ovf_seen;
            v.matched = ovf_seen ? 1'b0 : glob_matches();
            verdict_queue.push_back(v);
            pat_mem.delete(); txt_mem.delete(); ovf_seen = 0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic logic [15:0] mk(input logic [1:0] op, input logic [7:0] b);
        return {6'b0, b, op};
    endfunction

    task automatic add_str(input logic [1:0] op, input string str);
        foreach (str[i]) req_queue.push_back(mk(op, str[i]));
    endtask

    task automatic add_case(input string pat, input string txt);
        add_str(OP_PAT, pat);
        add_str(OP_TXT, txt);
        req_queue.push_back(mk(OP_RUN, 8'h00));
    endtask

    // Byte biased towards pattern metacharacters and a small alphabet.
    function automatic logic [7:0] rand_pat_byte();
        case ($urandom_range(0, 9))
            0: return CH_STAR;
            1: return CH_QUEST;
            2: return CH_LBRK;
            3: return CH_RBRK;
            4: begin
                case ($urandom_range(0, 3))
                    0: return CH_BANG;
                    1: return CH_CARET;
                    2: return CH_DASH;
                    default: return CH_BSL;
                endcase
            end
            5: return 8'($urandom_range(1, 255));
            default: return 8'h61 + 8'($urandom_range(0, 3));
        endcase
    endfunction

    // Records whether the offered request was taken at the last rising edge.
    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
    end

    // Driver: offers the next pending request, idling at random.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_taken) begin
                // hold the offered request
            end else if (drain_req || req_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!quiet_sender && $urandom_range(0, 99) < 18) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= req_queue.pop_front();
            end
        end
    end

    // Receiver readiness, including a long counted hold-off.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (quiet_receiver) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 18);
        end
    end

    // Monitor: accepted requests feed the predictor, results are checked.
    always @(posedge aclk) begin
        verdict_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_request(s_tdata);
            if (m_tvalid && m_tready) begin
                got.matched = m_tdata[0];
                got.overflowed = m_tdata[1];
                if (verdict_queue.size() == 0) begin
                    report_mismatch("result with none expected");
                end else begin
                    want = verdict_queue.pop_front();
                    if (got.matched !== want.matched)
                        report_mismatch($sformatf("matched %b, expected %b",
                            got.matched, want.matched));
                    if (got.overflowed !== want.overflowed)
                        report_mismatch($sformatf("overflowed %b, expected %b",
                            got.overflowed, want.overflowed));
                    if (m_tdata[7:2] !== 6'b0) report_mismatch("nonzero padding");
                end
            end
        end
    end

    task automatic wait_idle();
        while (req_queue.size() != 0 || s_tvalid || verdict_queue.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int n, k;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed cases: each metacharacter and the corner cases of the language.
        add_case("", "");
        add_case("abc", "abc");
        add_case("a*c", "abbbc");
        add_case("a?c", "ac");
        add_case("[!a-c]x", "dx");
        add_case("[^a]", "a");
        add_case("[]]", "]");
        add_case("[\\]]z", "]z");
        add_case("[a-\\z]", "q");
        add_case("[ab", "[");
        add_case("\\*", "*");
        add_case("a\\", "a\\");
        add_case("a***", "a");
        add_case("*b*b", "abxbyb");
        add_case("[a-]", "-");
        // Zero bytes and operation 3 are dropped silently.
        req_queue.push_back(mk(OP_PAT, 8'h00));
        req_queue.push_back(mk(OP_NOP, 8'hFF));
        req_queue.push_back(mk(OP_TXT, 8'hFF));
        req_queue.push_back(mk(OP_PAT, 8'hFF));
        req_queue.push_back(mk(OP_RUN, 8'hFF));
        wait_idle();

        // Overflow of both stores, each reported then cleared.
        for (int i = 0; i < PATTERN_DEPTH_DEF + 1; i++) req_queue.push_back(mk(OP_PAT, 8'h2A));
        req_queue.push_back(mk(OP_RUN, 8'h00));
        for (int i = 0; i < TEXT_DEPTH_DEF; i++) req_queue.push_back(mk(OP_TXT, 8'h61));
        req_queue.push_back(mk(OP_PAT, CH_STAR));
        req_queue.push_back(mk(OP_RUN, 8'h00));
        for (int i = 0; i < TEXT_DEPTH_DEF + 1; i++) req_queue.push_back(mk(OP_TXT, 8'h61));
        req_queue.push_back(mk(OP_RUN, 8'h00));
        wait_idle();
        // Sender pause until every verdict is back, then a long receiver hold-off.
        drain_req = 1;
        wait_idle();
        repeat (4) @(posedge aclk);
        drain_req = 0;

        @(negedge aclk);
        hold_cycles = 300;
        for (int i = 0; i < 8; i++) add_case("a*", "ab");
        wait_idle();

        // Random part: mostly short well-formed runs, some raw noise.
        n = 0;
        while (n < 480) begin
            if ($urandom_range(0, 9) == 0) begin
                req_queue.push_back(16'($urandom_range(0, 1023)));
                n++;
            end else begin
                k = $urandom_range(0, 8);
                for (int i = 0; i < k; i++) req_queue.push_back(mk(OP_PAT, rand_pat_byte()));
                k = $urandom_range(0, 10);
                for (int i = 0; i < k; i++)
                    req_queue.push_back(mk(OP_TXT, ($urandom_range(0, 4) == 0) ?
                        rand_pat_byte() : 8'h61 + 8'($urandom_range(0, 3))));
                req_queue.push_back(mk(OP_RUN, 8'($urandom_range(0, 255))));
                n += req_queue.size();
            end
            if (n > 150 && n < 300) begin
                quiet_sender = 1; quiet_receiver = 1;
            end else begin
                quiet_sender = 0; quiet_receiver = 0;
            end
            wait_idle();
        end

        wait_idle();
        repeat (2000) @(posedge aclk);
        if (error_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #100ms;
        $display("Verification failed");
        $finish;
    end
endmodule

>>> filelist.f
rtl/gpm_pkg.sv
rtl/gpm_ram.sv
rtl/glob_pattern_matcher_core.sv
tb/tb.sv
